/* hw/rtl/jfsp_pkg.sv */
package jfsp_pkg;

  localparam int PhaseW = 4;

  localparam logic [PhaseW-1:0] PH_SOI0   = 4'd0;
  localparam logic [PhaseW-1:0] PH_SOI1   = 4'd1;
  localparam logic [PhaseW-1:0] PH_SCAN   = 4'd2;
  localparam logic [PhaseW-1:0] PH_MARKER = 4'd3;
  localparam logic [PhaseW-1:0] PH_LEN1   = 4'd4;
  localparam logic [PhaseW-1:0] PH_LEN2   = 4'd5;
  localparam logic [PhaseW-1:0] PH_SKIP   = 4'd6;
  localparam logic [PhaseW-1:0] PH_SOF    = 4'd7;
  localparam logic [PhaseW-1:0] PH_DONE   = 4'd8;

  localparam logic [1:0] OUT_PENDING = 2'd0;
  localparam logic [1:0] OUT_FOUND   = 2'd1;
  localparam logic [1:0] OUT_FAILED  = 2'd2;

  localparam logic [7:0] MK_PREFIX = 8'hff;
  localparam logic [7:0] MK_SOI    = 8'hd8;
  localparam logic [7:0] MK_EOI    = 8'hd9;
  localparam logic [7:0] MK_TEM    = 8'h01;
  localparam logic [7:0] MK_SOF_LO = 8'hc0;
  localparam logic [7:0] MK_SOF_HI = 8'hc3;
  localparam logic [7:0] MK_SOS    = 8'hda;
  localparam logic [7:0] MK_RST_LO = 8'hd0;
  localparam logic [7:0] MK_RST_HI = 8'hd7;

  localparam logic [3:0] SOF_HEIGHT_HI = 4'd3;
  localparam logic [3:0] SOF_HEIGHT_LO = 4'd4;
  localparam logic [3:0] SOF_WIDTH_HI  = 4'd5;
  localparam logic [3:0] SOF_WIDTH_LO  = 4'd6;
  localparam logic [3:0] SOF_LAST      = 4'd7;

  localparam logic [15:0] MIN_SEG_LEN = 16'd2;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_file;
  } item_t;

  typedef struct packed {
    logic        size_found;
    logic [15:0] frame_width;
    logic [15:0] frame_height;
  } result_t;

endpackage

/* hw/rtl/jfsp_in_if.sv */
interface jfsp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_file;

  modport source (output valid, output data_byte, output end_of_file, input ready);
  modport sink (input valid, input data_byte, input end_of_file, output ready);
endinterface

/* hw/rtl/jfsp_out_if.sv */
interface jfsp_out_if;
  logic        valid;
  logic        ready;
  logic        size_found;
  logic [15:0] frame_width;
  logic [15:0] frame_height;

  modport source (output valid, output size_found, output frame_width, output frame_height,
                  input ready);
  modport sink (input valid, input size_found, input frame_width, input frame_height,
                output ready);
endinterface

/* hw/rtl/jfsp_in_stage.sv */
module jfsp_in_stage (
  input  logic            clk,
  input  logic            rst,
  jfsp_in_if.sink         bytes,
  input  logic            take,
  output logic            item_valid,
  output jfsp_pkg::item_t item
);
  import jfsp_pkg::*;

  logic valid;

  assign bytes.ready = !valid || take;
  assign item_valid  = valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (bytes.ready) begin
      valid <= bytes.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (bytes.ready && bytes.valid) begin
      item.data_byte   <= bytes.data_byte;
      item.end_of_file <= bytes.end_of_file;
    end
  end

endmodule

/* hw/rtl/jfsp_parser.sv */
module jfsp_parser (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  jfsp_pkg::item_t   item,
  output jfsp_pkg::result_t result
);
  import jfsp_pkg::*;

  logic [PhaseW-1:0] phase, phase_next;
  logic [15:0]       skip_left, skip_left_next;
  logic [3:0]        hdr_idx, hdr_idx_next;
  logic [15:0]       height, height_next;
  logic [15:0]       width, width_next;
  logic [1:0]        outcome, outcome_next;
  logic [7:0]        b;
  logic [15:0]       seg_len;
  logic              is_sof, is_standalone;

  assign b       = item.data_byte;
  assign seg_len = {skip_left[15:8], b};
  assign is_sof  = (b >= MK_SOF_LO) && (b <= MK_SOF_HI);
  assign is_standalone = (b == MK_SOI) || (b == MK_EOI) || (b == MK_TEM)
                         || ((b >= MK_RST_LO) && (b <= MK_RST_HI));

  always_comb begin
    phase_next     = phase;
    skip_left_next = skip_left;
    hdr_idx_next   = hdr_idx;
    height_next    = height;
    width_next     = width;
    outcome_next   = outcome;
    unique case (phase)
      PH_SOI0: begin
        if (b == MK_PREFIX) begin
          phase_next = PH_SOI1;
        end else begin
          phase_next   = PH_DONE;
          outcome_next = OUT_FAILED;
        end
      end
      PH_SOI1: begin
        if (b == MK_SOI) begin
          phase_next = PH_SCAN;
        end else begin
          phase_next   = PH_DONE;
          outcome_next = OUT_FAILED;
        end
      end
      PH_SCAN: begin
        if (b == MK_PREFIX) phase_next = PH_MARKER;
      end
      PH_MARKER: begin
        priority if (is_sof) begin
          hdr_idx_next = 4'd0;
          phase_next   = PH_SOF;
        end else if (b == MK_SOS) begin
          phase_next   = PH_DONE;
          outcome_next = OUT_FAILED;
        end else if (is_standalone) begin
          phase_next = PH_SCAN;
        end else begin
          phase_next = PH_LEN1;
        end
      end
      PH_LEN1: begin
        skip_left_next = {b, 8'h00};
        phase_next     = PH_LEN2;
      end
      PH_LEN2: begin
        if (seg_len < MIN_SEG_LEN) begin
          phase_next   = PH_DONE;
          outcome_next = OUT_FAILED;
        end else begin
          skip_left_next = seg_len - MIN_SEG_LEN;
          phase_next     = (seg_len == MIN_SEG_LEN) ? PH_SCAN : PH_SKIP;
        end
      end
      PH_SKIP: begin
        skip_left_next = skip_left - 16'd1;
        if (skip_left == 16'd1) phase_next = PH_SCAN;
      end
      PH_SOF: begin
        unique case (hdr_idx)
          SOF_HEIGHT_HI: height_next = {b, 8'h00};
          SOF_HEIGHT_LO: height_next = {height[15:8], b};
          SOF_WIDTH_HI:  width_next  = {b, 8'h00};
          SOF_WIDTH_LO:  width_next  = {width[15:8], b};
          default: ;
        endcase
        if (hdr_idx >= SOF_LAST) begin
          phase_next   = PH_DONE;
          outcome_next = ((width != 16'd0) && (height != 16'd0)) ? OUT_FOUND : OUT_FAILED;
        end else begin
          hdr_idx_next = hdr_idx + 4'd1;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    if (outcome_next == OUT_FOUND) begin
      result.size_found   = 1'b1;
      result.frame_width  = width_next;
      result.frame_height = height_next;
    end else begin
      result.size_found   = 1'b0;
      result.frame_width  = 16'd0;
      result.frame_height = 16'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (step && item.end_of_file)) begin
      phase     <= PH_SOI0;
      skip_left <= 16'd0;
      hdr_idx   <= 4'd0;
      height    <= 16'd0;
      width     <= 16'd0;
      outcome   <= OUT_PENDING;
    end else if (step) begin
      phase     <= phase_next;
      skip_left <= skip_left_next;
      hdr_idx   <= hdr_idx_next;
      height    <= height_next;
      width     <= width_next;
      outcome   <= outcome_next;
    end
  end

  a_found_nonzero: assert property (@(posedge clk) disable iff (rst)
    outcome == OUT_FOUND |-> (width != 16'd0) && (height != 16'd0))
    else $error("found without nonzero size");

  a_done_decided: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_DONE) == (outcome != OUT_PENDING))
    else $error("done phase and outcome disagree");

  a_eof_clears: assert property (@(posedge clk) disable iff (rst)
    step && item.end_of_file |=> phase == PH_SOI0 && outcome == OUT_PENDING)
    else $error("state not cleared after last byte");

  a_skip_nonzero: assert property (@(posedge clk) disable iff (rst)
    phase == PH_SKIP |-> skip_left != 16'd0)
    else $error("skip phase with nothing to skip");

endmodule

/* hw/rtl/jfsp_out_stage.sv */
module jfsp_out_stage (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  jfsp_pkg::result_t result_in,
  output logic              space,
  jfsp_out_if.source        result
);
  import jfsp_pkg::*;

  logic    valid;
  result_t held;

  assign space               = !valid || result.ready;
  assign result.valid        = valid;
  assign result.size_found   = held.size_found;
  assign result.frame_width  = held.frame_width;
  assign result.frame_height = held.frame_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (space) begin
      valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (space && load) begin
      held <= result_in;
    end
  end

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    load |-> space)
    else $error("result loaded over a waiting item");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    valid && !held.size_found |-> held.frame_width == 16'd0 && held.frame_height == 16'd0)
    else $error("failed result with nonzero size");

endmodule

/* hw/rtl/jpeg_frame_size_probe_core.sv */
// JPEG frame size probe.
// bytes:  one file byte per item (data_byte) with end_of_file set on the last
//         byte of the file. Files follow each other with no gap.
// result: one item per file, given for its last byte: size_found, frame_width,
//         frame_height (SOF0..SOF3 dimensions, all zero when not found).
// Path: a last byte is held in the input register, then the parser result
//   for it is loaded into the result register, which drives result.valid.
// Throughput: one byte per cycle while results are taken, including back-to-back files.
//   The parser state is updated once per byte.
// Stall: a waiting result holds until taken. Bytes other than the last one
//   keep flowing; a last byte waits in the input register while the previous
//   result is still held, and bytes.ready drops once that register is full.
// Reset: rst (synchronous) empties both registers and returns the parser to
//   waiting for the FF D8 start of a file. The parser also returns there by
//   itself after every last byte.
module jpeg_frame_size_probe_core (
  input  logic       clk,
  input  logic       rst,
  jfsp_in_if.sink    bytes,
  jfsp_out_if.source result
);
  import jfsp_pkg::*;

  logic    item_valid;
  item_t   item;
  logic    advance;
  logic    out_space;
  result_t parsed;

  assign advance = item_valid && (!item.end_of_file || out_space);

  jfsp_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .bytes      (bytes),
    .take       (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  jfsp_parser u_parser (
    .clk    (clk),
    .rst    (rst),
    .step   (advance),
    .item   (item),
    .result (parsed)
  );

  jfsp_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (advance && item.end_of_file),
    .result_in (parsed),
    .space     (out_space),
    .result    (result)
  );

endmodule
